FILE: rtl/sbsm_pkg.sv
// Shared types and constants for the serial bank-switch mapper.
package sbsm_pkg;

    // Bus access kinds carried by the op field.
    typedef enum logic [2:0] {
        OP_CPU_RD = 3'd0,
        OP_CPU_WR = 3'd1,
        OP_PPU_RD = 3'd2,
        OP_PPU_WR = 3'd3,
        OP_MAP_RST = 3'd4
    } t_op;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PRG_BANKS = 2'd0;
    localparam logic [1:0] CFG_CHR_BANKS = 2'd1;

    // Serial register targets, address bits 14:13.
    localparam logic [1:0] TGT_CONTROL  = 2'd0;
    localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
    localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
    localparam logic [1:0] TGT_PRG      = 2'd3;

    // PRG banking modes, control bits 3:2; the two lower codes select 32K banking.
    localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_FIX_LAST  = 2'd3;

    localparam logic [4:0] CONTROL_RESET   = 5'h1C;
    localparam logic [4:0] PRG_BANKS_RESET = 5'd8;
    localparam logic [5:0] CHR_BANKS_RESET = 6'd1;
    localparam logic [2:0] SHIFT_LAST      = 3'd4;

    // One result item.
    typedef struct packed {
        logic        hit;
        logic        addr_valid;
        logic [17:0] mapped_address;
        logic        ram_read;
        logic [1:0]  mirror_mode;
    } t_result;

    // Cartridge RAM request; offset is the low 13 address bits.
    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [12:0] offset;
        logic [7:0]  wdata;
    } t_ram_req;

endpackage

FILE: rtl/serial_bank_switch_mapper.sv
// Top level of the serial bank-switch mapper: request channels and result register.
//
//   Channel   Direction  Handshake               Payload
//   in        to block   i_in_valid/o_in_stall   i_in_op, i_in_addr, i_in_data
//   out       from block o_out_valid/i_out_stall o_out_hit .. o_out_mirror_mode
//   cfg       to block   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Each request's result appears in the output register in the cycle after
// acceptance, with RAM read data from the memory's registered port.
// A new request is taken every cycle while the output register is empty or drained.
// Reset is synchronous; it clears the mapper registers, not the cartridge RAM.
// A stalled result holds the output register and the RAM read port idle.
module serial_bank_switch_mapper #(
    parameter int CART_RAM_DEPTH = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_in_op,
    input  logic [15:0] i_in_addr,
    input  logic [7:0]  i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_hit,
    output logic        o_out_addr_valid,
    output logic [17:0] o_out_mapped_address,
    output logic [7:0]  o_out_read_data,
    output logic [1:0]  o_out_mirror_mode,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    import sbsm_pkg::*;

    logic     accept;
    logic     r_out_valid;
    t_result  r_res;
    t_result  res;
    t_ram_req ram_req;
    logic [7:0] ram_rdata;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    sbsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_in_op),
        .i_addr      (i_in_addr),
        .i_data      (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (res),
        .o_ram       (ram_req)
    );

    sbsm_ram #(
        .CART_RAM_DEPTH (CART_RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_hit            = r_res.hit;
    assign o_out_addr_valid     = r_res.addr_valid;
    assign o_out_mapped_address = r_res.mapped_address;
    assign o_out_read_data      = r_res.ram_read ? ram_rdata : 8'd0;
    assign o_out_mirror_mode    = r_res.mirror_mode;

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted request produced no result");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_hit) |->
        (!o_out_addr_valid && o_out_mapped_address == 18'd0 && o_out_read_data == 8'd0))
        else $error("unclaimed access carries nonzero fields");

    a_valid_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_addr_valid) |-> o_out_hit)
        else $error("translated address without a claimed access");

    a_ram_read_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_res.ram_read) |-> (!o_out_addr_valid && o_out_hit))
        else $error("RAM read result also carries a translated address");

    a_stall_holds_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && r_res.ram_read) |=> $stable(o_out_read_data))
        else $error("RAM read data changed while the result was stalled");
`endif

endmodule

FILE: rtl/sbsm_ram.sv
// Cartridge RAM: single-port synchronous memory with registered read data.
module sbsm_ram #(
    parameter int CART_RAM_DEPTH = 8192
) (
    input  logic              i_clk,
    input  sbsm_pkg::t_ram_req i_req,
    output logic [7:0]        o_rdata
);
    import sbsm_pkg::*;

    localparam int AW = $clog2(CART_RAM_DEPTH);
    localparam logic [16:0] DEPTH_X1 = 17'(CART_RAM_DEPTH);
    localparam logic [16:0] DEPTH_X2 = 17'(2 * CART_RAM_DEPTH);

    logic [7:0]  mem [CART_RAM_DEPTH];
    logic [16:0] v0, v1, v2;
    logic [AW-1:0] idx;
    logic [7:0]  r_rdata;

    // The offset is below four times the smallest depth, so two
    // compare-and-subtract steps reduce it modulo the depth.
    always_comb begin
        v0 = {4'd0, i_req.offset};
        v1 = (v0 >= DEPTH_X2) ? v0 - DEPTH_X2 : v0;
        v2 = (v1 >= DEPTH_X1) ? v1 - DEPTH_X1 : v1;
        idx = v2[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[idx] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[idx];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sbsm_ctrl.sv
// Mapper register file, serial loader and address translation.
module sbsm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [2:0]         i_op,
    input  logic [15:0]        i_addr,
    input  logic [7:0]         i_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [5:0]         i_cfg_data,
    output sbsm_pkg::t_result  o_res,
    output sbsm_pkg::t_ram_req o_ram
);
    import sbsm_pkg::*;

    logic [4:0] r_prg_banks;
    logic [5:0] r_chr_banks;
    logic [4:0] r_shift_value, n_shift_value;
    logic [2:0] r_shift_count, n_shift_count;
    logic [4:0] r_control, n_control;
    logic [4:0] r_chr_low, n_chr_low;
    logic [4:0] r_chr_high, n_chr_high;
    logic [4:0] r_chr_full, n_chr_full;
    logic [2:0] r_prg_full, n_prg_full;
    logic [3:0] r_prg_low, n_prg_low;
    logic [3:0] r_prg_high, n_prg_high;
    logic [1:0] r_mirror, n_mirror;

    logic       in_ram;
    logic [4:0] load_value;
    logic [3:0] last_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_banks <= PRG_BANKS_RESET;
            r_chr_banks <= CHR_BANKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRG_BANKS: r_prg_banks <= i_cfg_data[4:0];
                CFG_CHR_BANKS: r_chr_banks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_value <= '0;
            r_shift_count <= '0;
            r_control     <= CONTROL_RESET;
            r_chr_low     <= '0;
            r_chr_high    <= '0;
            r_chr_full    <= '0;
            r_prg_full    <= '0;
            r_prg_low     <= '0;
            r_prg_high    <= 4'(PRG_BANKS_RESET - 5'd1);
            r_mirror      <= '0;
        end else if (i_accept) begin
            r_shift_value <= n_shift_value;
            r_shift_count <= n_shift_count;
            r_control     <= n_control;
            r_chr_low     <= n_chr_low;
            r_chr_high    <= n_chr_high;
            r_chr_full    <= n_chr_full;
            r_prg_full    <= n_prg_full;
            r_prg_low     <= n_prg_low;
            r_prg_high    <= n_prg_high;
            r_mirror      <= n_mirror;
        end
    end

    assign in_ram     = (i_addr[15:13] == 3'b011);
    assign load_value = {i_data[0], r_shift_value[4:1]};
    assign last_bank  = 4'(r_prg_banks - 5'd1);

    always_comb begin
        n_shift_value = r_shift_value;
        n_shift_count = r_shift_count;
        n_control     = r_control;
        n_chr_low     = r_chr_low;
        n_chr_high    = r_chr_high;
        n_chr_full    = r_chr_full;
        n_prg_full    = r_prg_full;
        n_prg_low     = r_prg_low;
        n_prg_high    = r_prg_high;
        n_mirror      = r_mirror;

        o_res = '0;
        o_ram.wr_en  = 1'b0;
        o_ram.rd_en  = 1'b0;
        o_ram.offset = i_addr[12:0];
        o_ram.wdata  = i_data;

        case (t_op'(i_op))
            OP_CPU_RD: begin
                if (in_ram) begin
                    o_res.hit      = 1'b1;
                    o_res.ram_read = 1'b1;
                    o_ram.rd_en    = i_accept;
                end else if (i_addr[15]) begin
                    o_res.hit        = 1'b1;
                    o_res.addr_valid = 1'b1;
                    if (r_control[3]) begin
                        o_res.mapped_address = i_addr[14] ? {r_prg_high, i_addr[13:0]}
                                                          : {r_prg_low, i_addr[13:0]};
                    end else begin
                        o_res.mapped_address = {r_prg_full, i_addr[14:0]};
                    end
                end
            end
            OP_CPU_WR: begin
                if (in_ram) begin
                    o_res.hit   = 1'b1;
                    o_ram.wr_en = i_accept;
                end else if (i_addr[15]) begin
                    if (i_data[7]) begin
                        n_shift_value = '0;
                        n_shift_count = '0;
                        n_control     = r_control | 5'h0C;
                    end else if (r_shift_count >= SHIFT_LAST) begin
                        // Fifth bit: commit the assembled value to its target.
                        n_shift_value = '0;
                        n_shift_count = '0;
                        case (i_addr[14:13])
                            TGT_CONTROL: begin
                                n_control = load_value;
                                n_mirror  = load_value[1:0];
                            end
                            TGT_CHR_LOW: begin
                                if (r_control[4]) begin
                                    n_chr_low = load_value;
                                end else begin
                                    n_chr_full = {load_value[4:1], 1'b0};
                                end
                            end
                            TGT_CHR_HIGH: begin
                                if (r_control[4]) begin
                                    n_chr_high = load_value;
                                end
                            end
                            TGT_PRG: begin
                                case (r_control[3:2])
                                    PRG_FIX_FIRST: begin
                                        n_prg_low  = '0;
                                        n_prg_high = load_value[3:0];
                                    end
                                    PRG_FIX_LAST: begin
                                        n_prg_low  = load_value[3:0];
                                        n_prg_high = last_bank;
                                    end
                                    default: n_prg_full = load_value[3:1];
                                endcase
                            end
                            default: ;
                        endcase
                    end else begin
                        n_shift_value = load_value;
                        n_shift_count = r_shift_count + 3'd1;
                    end
                end
            end
            OP_PPU_RD: begin
                if (i_addr[15:13] == 3'b000) begin
                    o_res.hit        = 1'b1;
                    o_res.addr_valid = 1'b1;
                    if (r_chr_banks == '0) begin
                        o_res.mapped_address = {2'd0, i_addr};
                    end else if (r_control[4]) begin
                        o_res.mapped_address = i_addr[12]
                            ? {1'b0, r_chr_high, i_addr[11:0]}
                            : {1'b0, r_chr_low, i_addr[11:0]};
                    end else begin
                        // The full bank is even, so the 8K window adds without carry.
                        o_res.mapped_address = {1'b0, r_chr_full[4:1], i_addr[12:0]};
                    end
                end
            end
            OP_PPU_WR: begin
                if (i_addr[15:13] == 3'b000) begin
                    o_res.hit = 1'b1;
                    if (r_chr_banks == '0) begin
                        o_res.addr_valid     = 1'b1;
                        o_res.mapped_address = {2'd0, i_addr};
                    end
                end
            end
            OP_MAP_RST: begin
                n_shift_value = '0;
                n_shift_count = '0;
                n_control     = CONTROL_RESET;
                n_chr_low     = '0;
                n_chr_high    = '0;
                n_chr_full    = '0;
                n_prg_full    = '0;
                n_prg_low     = '0;
                n_prg_high    = last_bank;
                n_mirror      = '0;
            end
            default: ;
        endcase

        o_res.mirror_mode = n_mirror;
    end

endmodule
